[rtl/multidim_histogram_counter_core_assert.svh]
// Assertion macros shared by the histogram counter RTL.
// Expects signals named clk and arst_n in the including module.
`ifndef MULTIDIM_HISTOGRAM_COUNTER_CORE_ASSERT_SVH
`define MULTIDIM_HISTOGRAM_COUNTER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MDHC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define MDHC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/mdhc_pkg.sv]
// Shared types, constants and codes of the histogram counter.
// No dependencies.
package mdhc_pkg;

	localparam int CELLS      = 4096;
	localparam int IDX_BITS   = $clog2(CELLS);
	localparam int COUNT_BITS = 32;
	localparam int COUNT_W    = 32;
	localparam int CELL_W     = 12;
	localparam int VAL_W      = 16;
	localparam int SIZE_W     = 13;
	localparam int OFF_W      = 12;
	localparam int DIFF_W     = VAL_W + 1;
	localparam int P1_W       = OFF_W + SIZE_W;
	localparam int B2_W       = 2 * SIZE_W;
	localparam int P2_W       = OFF_W + B2_W;
	localparam int SUM1_W     = P1_W + 1;
	localparam int ADDR_W     = 5;
	localparam int DATA_W     = 32;
	localparam logic [1:0] MAX_DIMS = 2'd3;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	typedef enum logic [1:0] {
		OP_COUNT = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2
	} op_e;

	typedef enum logic [2:0] {
		REG_DIMS  = 3'd0,
		REG_LOW0  = 3'd1,
		REG_LOW1  = 3'd2,
		REG_LOW2  = 3'd3,
		REG_SIZE0 = 3'd4,
		REG_SIZE1 = 3'd5,
		REG_SIZE2 = 3'd6
	} reg_e;

	typedef struct packed {
		logic [1:0]              dims;
		logic signed [VAL_W-1:0] low0;
		logic signed [VAL_W-1:0] low1;
		logic signed [VAL_W-1:0] low2;
		logic [SIZE_W-1:0]       size0;
		logic [SIZE_W-1:0]       size1;
		logic [SIZE_W-1:0]       size2;
	} cfg_t;

	typedef struct packed {
		logic                valid;
		op_e                 op;
		logic [IDX_BITS-1:0] addr;
		logic [CELL_W-1:0]   cell_id;
		logic                bad;
	} req_t;

endpackage

[rtl/multidim_histogram_counter_core.sv]
// Multidimensional histogram counter: mixed-radix cell index over up to three
// coordinates, saturating 32-bit counters in a 4096-entry memory.
// A start transfer passes the index pipeline, the read-modify-write stage and
// the result register before the done strobe. A new item is taken only once
// the last has left the index pipeline. Reset: registers reset at once; the count
// memory is then swept to zero with busy high. Results cannot be stalled.
`include "multidim_histogram_counter_core_assert.svh"

module multidim_histogram_counter_core (
	input  logic                               clk,
	input  logic                               arst_n,
	// command channel
	input  logic                               start,
	output logic                               busy,
	input  logic [1:0]                         opcode,
	input  logic signed [mdhc_pkg::VAL_W-1:0]  value_0,
	input  logic signed [mdhc_pkg::VAL_W-1:0]  value_1,
	input  logic signed [mdhc_pkg::VAL_W-1:0]  value_2,
	input  logic [mdhc_pkg::CELL_W-1:0]        read_index,
	// result channel
	output logic                               done,
	output logic [mdhc_pkg::COUNT_W-1:0]       count,
	output logic [mdhc_pkg::CELL_W-1:0]        cell_index,
	output logic                               status,
	// configuration port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [mdhc_pkg::ADDR_W-1:0]        paddr,
	input  logic [mdhc_pkg::DATA_W-1:0]        pwdata,
	output logic [mdhc_pkg::DATA_W-1:0]        prdata,
	output logic                               pready
);

	mdhc_pkg::cfg_t cfg;
	mdhc_pkg::req_t req;
	logic           idx_busy;
	logic           take;

	// memory clear sweep after reset
	logic                          clr_busy_q;
	logic [mdhc_pkg::IDX_BITS-1:0] clr_addr_q;

	// read-modify-write stage: memory data lands here
	logic                            v_s4;
	mdhc_pkg::op_e                   op_s4;
	logic [mdhc_pkg::IDX_BITS-1:0]   addr_s4;
	logic [mdhc_pkg::CELL_W-1:0]     cell_s4;
	logic                            bad_s4;
	logic [mdhc_pkg::COUNT_BITS-1:0] rdata;

	logic                            mem_we;
	logic [mdhc_pkg::IDX_BITS-1:0]   mem_waddr;
	logic [mdhc_pkg::COUNT_BITS-1:0] mem_wdata;
	logic                            wb_we;
	logic [mdhc_pkg::COUNT_BITS-1:0] wb_data;
	logic [mdhc_pkg::COUNT_BITS-1:0] res_count;

	logic                            done_q;
	logic [mdhc_pkg::COUNT_W-1:0]    count_q;
	logic [mdhc_pkg::CELL_W-1:0]     cell_index_q;
	logic                            status_q;

	assign pready = 1'b1;
	// stage 4 is left out of busy: the next item reads the memory only once it
	// has passed the index stages, well after this item's write-back
	assign busy   = clr_busy_q | idx_busy;
	assign take   = start & ~busy;

	mdhc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	mdhc_index u_index (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.opcode     (opcode),
		.value_0    (value_0),
		.value_1    (value_1),
		.value_2    (value_2),
		.read_index (read_index),
		.cfg        (cfg),
		.req        (req),
		.busy       (idx_busy)
	);

	mdhc_ram #(
		.WIDTH (mdhc_pkg::COUNT_BITS),
		.DEPTH (mdhc_pkg::CELLS)
	) u_counts (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (req.valid),
		.raddr (req.addr),
		.rdata (rdata)
	);

	// clear sweep: one entry a cycle from address zero up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == mdhc_pkg::IDX_BITS'(mdhc_pkg::CELLS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		op_s4   <= req.op;
		addr_s4 <= req.addr;
		cell_s4 <= req.cell_id;
		bad_s4  <= req.bad;
	end

	// modify: saturating increment for counts, zero for read-and-clear
	always_comb begin
		wb_we     = 1'b0;
		wb_data   = '0;
		res_count = '0;
		if (!bad_s4) begin
			unique case (op_s4) inside
				mdhc_pkg::OP_COUNT: begin
					wb_we     = 1'b1;
					wb_data   = (rdata == mdhc_pkg::CNT_MAX) ? rdata : rdata + 1'b1;
					res_count = wb_data;
				end
				mdhc_pkg::OP_READ: begin
					res_count = rdata;
				end
				mdhc_pkg::OP_CLEAR: begin
					wb_we     = 1'b1;
					res_count = rdata;
				end
				default: ;
			endcase
		end
	end

	// write port: the sweep owns it until done, then the write-back
	assign mem_we    = clr_busy_q | (v_s4 & wb_we);
	assign mem_waddr = clr_busy_q ? clr_addr_q : addr_s4;
	assign mem_wdata = clr_busy_q ? '0 : wb_data;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s4) begin
			count_q      <= res_count[mdhc_pkg::COUNT_W-1:0];
			cell_index_q <= cell_s4;
			status_q     <= bad_s4;
		end
	end

	assign done       = done_q;
	assign count      = count_q;
	assign cell_index = cell_index_q;
	assign status     = status_q;

	`MDHC_ASSERT_NOW(a_no_wb_in_sweep, clr_busy_q, !v_s4, "write-back collides with clear sweep")
	`MDHC_ASSERT_NEXT(a_take_sets_busy, take, busy, "busy not raised after transfer")
	`MDHC_ASSERT_NOW(a_bad_zero_count, done && status, count == '0, "rejected item reports a count")
	`MDHC_ASSERT_NEXT(a_s4_gives_done, v_s4, done, "read-modify-write stage without a result")

endmodule

[rtl/mdhc_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module mdhc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/mdhc_cfg.sv]
// APB-style configuration registers of the histogram counter.
// Depends on mdhc_pkg.
module mdhc_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [mdhc_pkg::ADDR_W-1:0] paddr,
	input  logic [mdhc_pkg::DATA_W-1:0] pwdata,
	output logic [mdhc_pkg::DATA_W-1:0] prdata,
	output mdhc_pkg::cfg_t             cfg
);

	mdhc_pkg::cfg_t cfg_q;
	mdhc_pkg::reg_e sel;
	logic           wr;

	assign sel = mdhc_pkg::reg_e'(paddr[4:2]);
	assign wr  = psel & penable & pwrite;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dims  <= 2'd1;
			cfg_q.low0  <= '0;
			cfg_q.low1  <= '0;
			cfg_q.low2  <= '0;
			cfg_q.size0 <= mdhc_pkg::SIZE_W'(1);
			cfg_q.size1 <= mdhc_pkg::SIZE_W'(1);
			cfg_q.size2 <= mdhc_pkg::SIZE_W'(1);
		end else if (wr) begin
			unique case (sel)
				mdhc_pkg::REG_DIMS:  cfg_q.dims  <= pwdata[1:0];
				mdhc_pkg::REG_LOW0:  cfg_q.low0  <= pwdata[mdhc_pkg::VAL_W-1:0];
				mdhc_pkg::REG_LOW1:  cfg_q.low1  <= pwdata[mdhc_pkg::VAL_W-1:0];
				mdhc_pkg::REG_LOW2:  cfg_q.low2  <= pwdata[mdhc_pkg::VAL_W-1:0];
				mdhc_pkg::REG_SIZE0: cfg_q.size0 <= pwdata[mdhc_pkg::SIZE_W-1:0];
				mdhc_pkg::REG_SIZE1: cfg_q.size1 <= pwdata[mdhc_pkg::SIZE_W-1:0];
				mdhc_pkg::REG_SIZE2: cfg_q.size2 <= pwdata[mdhc_pkg::SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (sel)
			mdhc_pkg::REG_DIMS:  prdata = mdhc_pkg::DATA_W'(cfg_q.dims);
			mdhc_pkg::REG_LOW0:  prdata = mdhc_pkg::DATA_W'(unsigned'(cfg_q.low0));
			mdhc_pkg::REG_LOW1:  prdata = mdhc_pkg::DATA_W'(unsigned'(cfg_q.low1));
			mdhc_pkg::REG_LOW2:  prdata = mdhc_pkg::DATA_W'(unsigned'(cfg_q.low2));
			mdhc_pkg::REG_SIZE0: prdata = mdhc_pkg::DATA_W'(cfg_q.size0);
			mdhc_pkg::REG_SIZE1: prdata = mdhc_pkg::DATA_W'(cfg_q.size1);
			mdhc_pkg::REG_SIZE2: prdata = mdhc_pkg::DATA_W'(cfg_q.size2);
			default:             prdata = '0;
		endcase
	end

endmodule

[rtl/mdhc_index.sv]
// Three-stage cell index pipeline: offsets and range checks, products, final sum.
// Depends on mdhc_pkg and multidim_histogram_counter_core_assert.svh.
`include "multidim_histogram_counter_core_assert.svh"

module mdhc_index (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              take,
	input  logic [1:0]                        opcode,
	input  logic signed [mdhc_pkg::VAL_W-1:0] value_0,
	input  logic signed [mdhc_pkg::VAL_W-1:0] value_1,
	input  logic signed [mdhc_pkg::VAL_W-1:0] value_2,
	input  logic [mdhc_pkg::CELL_W-1:0]       read_index,
	input  mdhc_pkg::cfg_t                    cfg,
	output mdhc_pkg::req_t                    req,
	output logic                              busy
);

	// stage 0 (input side): offsets and range checks
	logic signed [mdhc_pkg::DIFF_W-1:0] diff0, diff1, diff2;
	logic                               bad0, bad1, bad2;
	logic [1:0]                         dimc;

	// stage registers
	logic                              v_s1, v_s2, v_s3;
	mdhc_pkg::op_e                     op_s1, op_s2, op_s3;
	logic [mdhc_pkg::CELL_W-1:0]       ri_s1, ri_s2, ri_s3;
	logic                              bad_s1, bad_s2, bad_s3;
	logic [mdhc_pkg::OFF_W-1:0]        off0_s1, off1_s1, off2_s1;
	logic [mdhc_pkg::OFF_W-1:0]        off0_s2, off2_s2;
	logic [mdhc_pkg::P1_W-1:0]         p1_s2;
	logic [mdhc_pkg::B2_W-1:0]         b2_s2;
	logic [mdhc_pkg::P2_W-1:0]         p2_s3;
	logic [mdhc_pkg::SUM1_W-1:0]       sum1_s3;

	logic [mdhc_pkg::P2_W-1:0]         idx;
	logic                              over;
	logic                              ri_over;

	function automatic logic signed [mdhc_pkg::DIFF_W-1:0] DIFF_EXT(
		input logic signed [mdhc_pkg::VAL_W-1:0] v);
		DIFF_EXT = {v[mdhc_pkg::VAL_W-1], v};
	endfunction

	assign diff0 = DIFF_EXT(value_0) - DIFF_EXT(cfg.low0);
	assign diff1 = DIFF_EXT(value_1) - DIFF_EXT(cfg.low1);
	assign diff2 = DIFF_EXT(value_2) - DIFF_EXT(cfg.low2);

	always_comb begin
		dimc = cfg.dims;
		if (dimc == 2'd0) begin
			dimc = 2'd1;
		end else if (dimc > mdhc_pkg::MAX_DIMS) begin
			dimc = mdhc_pkg::MAX_DIMS;
		end
		bad0 = diff0[mdhc_pkg::DIFF_W-1] ||
			(diff0[mdhc_pkg::VAL_W-1:0] >= mdhc_pkg::VAL_W'(cfg.size0));
		bad1 = (dimc >= 2'd2) && (diff1[mdhc_pkg::DIFF_W-1] ||
			(diff1[mdhc_pkg::VAL_W-1:0] >= mdhc_pkg::VAL_W'(cfg.size1)));
		bad2 = (dimc >= 2'd3) && (diff2[mdhc_pkg::DIFF_W-1] ||
			(diff2[mdhc_pkg::VAL_W-1:0] >= mdhc_pkg::VAL_W'(cfg.size2)));
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// payload; unused dimensions contribute a zero digit
	always_ff @(posedge clk) begin
		if (take) begin
			op_s1   <= mdhc_pkg::op_e'(opcode);
			ri_s1   <= read_index;
			bad_s1  <= bad0 | bad1 | bad2;
			off0_s1 <= diff0[mdhc_pkg::OFF_W-1:0];
			off1_s1 <= (dimc >= 2'd2) ? diff1[mdhc_pkg::OFF_W-1:0] : '0;
			off2_s1 <= (dimc >= 2'd3) ? diff2[mdhc_pkg::OFF_W-1:0] : '0;
		end
		op_s2   <= op_s1;
		ri_s2   <= ri_s1;
		bad_s2  <= bad_s1;
		off0_s2 <= off0_s1;
		off2_s2 <= off2_s1;
		p1_s2   <= mdhc_pkg::P1_W'(off1_s1) * mdhc_pkg::P1_W'(cfg.size0);
		b2_s2   <= mdhc_pkg::B2_W'(cfg.size0) * mdhc_pkg::B2_W'(cfg.size1);
		op_s3   <= op_s2;
		ri_s3   <= ri_s2;
		bad_s3  <= bad_s2;
		p2_s3   <= mdhc_pkg::P2_W'(off2_s2) * mdhc_pkg::P2_W'(b2_s2);
		sum1_s3 <= mdhc_pkg::SUM1_W'(off0_s2) + mdhc_pkg::SUM1_W'(p1_s2);
	end

	assign idx     = mdhc_pkg::P2_W'(sum1_s3) + p2_s3;
	assign over    = idx >= mdhc_pkg::P2_W'(mdhc_pkg::CELLS);
	assign ri_over = {1'b0, ri_s3} >= (mdhc_pkg::CELL_W + 1)'(mdhc_pkg::CELLS);

	always_comb begin
		req.valid   = v_s3;
		req.op      = op_s3;
		req.addr    = idx[mdhc_pkg::IDX_BITS-1:0];
		req.cell_id = '0;
		req.bad     = 1'b1;
		unique case (op_s3) inside
			mdhc_pkg::OP_COUNT: begin
				req.bad     = bad_s3 | over;
				req.cell_id = req.bad ? '0 :
					mdhc_pkg::CELL_W'(idx[mdhc_pkg::IDX_BITS-1:0]);
			end
			mdhc_pkg::OP_READ, mdhc_pkg::OP_CLEAR: begin
				req.addr    = ri_s3[mdhc_pkg::IDX_BITS-1:0];
				req.cell_id = ri_s3;
				req.bad     = ri_over;
			end
			default: begin
				req.bad     = 1'b1;
				req.cell_id = '0;
			end
		endcase
	end

	assign busy = v_s1 | v_s2 | v_s3;

	`MDHC_ASSERT_NOW(a_one_in_flight, 1'b1, $onehot0({v_s1, v_s2, v_s3}), "index pipeline holds more than one item")
	`MDHC_ASSERT_NEXT(a_take_fills_s1, take, v_s1 && $past(!busy), "item taken while pipeline busy")

endmodule

[bench/multidim_histogram_counter_core_test.sv]
// Self-checking bench for the multidimensional histogram counter core.
// Drives commands and APB register writes and checks each result against a
// built-in contingency-table model or a typed-in result. Needs mdhc_pkg and the core RTL only.
`timescale 1ns / 100ps

module multidim_histogram_counter_core_test;

	// Opcode 3 has no member in op_e; the core must flag it.
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_SETTINGS = 8;
	localparam int ITEMS_PER_SETTING = 210;

	typedef struct packed {
		logic [mdhc_pkg::COUNT_W-1:0] count;
		logic [mdhc_pkg::CELL_W-1:0]  cell_id;
		logic                         status;
	} histo_result_t;

	// One row of the directed table: a register write or a command, with an
	// optional result typed in by hand.
	typedef struct {
		bit                                is_cfg;
		mdhc_pkg::reg_e                    rsel;
		logic [mdhc_pkg::DATA_W-1:0]       wdata;
		logic [1:0]                        op;
		logic signed [mdhc_pkg::VAL_W-1:0] v0;
		logic signed [mdhc_pkg::VAL_W-1:0] v1;
		logic signed [mdhc_pkg::VAL_W-1:0] v2;
		logic [mdhc_pkg::CELL_W-1:0]       ridx;
		bit                                typed;
		histo_result_t                     known;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] opcode = '0;
	logic signed [mdhc_pkg::VAL_W-1:0] value_0 = '0;
	logic signed [mdhc_pkg::VAL_W-1:0] value_1 = '0;
	logic signed [mdhc_pkg::VAL_W-1:0] value_2 = '0;
	logic [mdhc_pkg::CELL_W-1:0] read_index = '0;
	logic done;
	logic [mdhc_pkg::COUNT_W-1:0] count;
	logic [mdhc_pkg::CELL_W-1:0] cell_index;
	logic status;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [mdhc_pkg::ADDR_W-1:0] paddr = '0;
	logic [mdhc_pkg::DATA_W-1:0] pwdata = '0;
	logic [mdhc_pkg::DATA_W-1:0] prdata;
	logic pready;

	// Shadow of the table and of the register file.
	logic [mdhc_pkg::COUNT_BITS-1:0] tally [mdhc_pkg::CELLS];
	logic [1:0] axes;
	logic signed [mdhc_pkg::VAL_W-1:0] lower_bound [3];
	logic [mdhc_pkg::SIZE_W-1:0] span [3];

	histo_result_t pending [$];
	plan_row_t plan [$];
	int mismatch_count = 0;
	int calm_left = 0;
	int obs_binned = 0;
	int obs_flagged = 0;
	int reads_done = 0;
	int clears_done = 0;
	int settings_used = 1;

	multidim_histogram_counter_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.value_0(value_0),
		.value_1(value_1),
		.value_2(value_2),
		.read_index(read_index),
		.done(done),
		.count(count),
		.cell_index(cell_index),
		.status(status),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop in case the core hangs or never answers.
	initial begin
		#3_000_000;
		$display("Verification failed");
		$finish;
	end

	task automatic report_mismatch(string what, longint got, longint wanted);
		$display("MISMATCH %s: got %0d, wanted %0d at %0t", what, got, wanted, $realtime);
		mismatch_count++;
	endtask

	// Bin one item into the shadow table and return the result it must give.
	// Offsets are formed at full precision so wrap-around can never hide a
	// coordinate that falls outside its range.
	function automatic histo_result_t tally_item(logic [1:0] op,
			logic signed [mdhc_pkg::VAL_W-1:0] v0, logic signed [mdhc_pkg::VAL_W-1:0] v1,
			logic signed [mdhc_pkg::VAL_W-1:0] v2, logic [mdhc_pkg::CELL_W-1:0] ridx);
		histo_result_t r;
		longint coord [3];
		longint off;
		longint cell_no;
		longint radix;
		int used;
		bit bad;
		r = '0;
		r.status = 1'b1;
		coord[0] = v0;
		coord[1] = v1;
		coord[2] = v2;
		if (op == mdhc_pkg::OP_COUNT) begin
			// A dimension count of zero behaves as one.
			used = (axes == 2'd0) ? 1 : int'(axes);
			cell_no = 0;
			radix = 1;
			bad = 1'b0;
			for (int k = 0; k < used; k++) begin
				off = coord[k] - longint'(lower_bound[k]);
				if (off < 0 || off >= longint'(span[k]))
					bad = 1'b1;
				cell_no += off * radix;
				radix *= longint'(span[k]);
			end
			// Drop anything out of range or past the end of the table.
			if (!bad && cell_no < mdhc_pkg::CELLS) begin
				if (tally[cell_no] != mdhc_pkg::CNT_MAX)
					tally[cell_no]++;
				r.count = tally[cell_no];
				r.cell_id = cell_no[mdhc_pkg::CELL_W-1:0];
				r.status = 1'b0;
			end
		end else if (op == mdhc_pkg::OP_READ || op == mdhc_pkg::OP_CLEAR) begin
			r.count = tally[ridx];
			r.cell_id = ridx;
			r.status = 1'b0;
			if (op == mdhc_pkg::OP_CLEAR)
				tally[ridx] = '0;
		end
		return r;
	endfunction

	function automatic void add_cfg(mdhc_pkg::reg_e r, int data);
		plan_row_t row;
		row.is_cfg = 1'b1;
		row.rsel = r;
		row.wdata = data;
		row.typed = 1'b0;
		plan.push_back(row);
	endfunction

	function automatic void add_item(bit typed, logic [1:0] op, int v0, int v1, int v2,
			int ridx, longint c, int cl, bit st);
		plan_row_t row;
		row.is_cfg = 1'b0;
		row.op = op;
		row.v0 = mdhc_pkg::VAL_W'(v0);
		row.v1 = mdhc_pkg::VAL_W'(v1);
		row.v2 = mdhc_pkg::VAL_W'(v2);
		row.ridx = mdhc_pkg::CELL_W'(ridx);
		row.typed = typed;
		row.known.count = mdhc_pkg::COUNT_W'(c);
		row.known.cell_id = mdhc_pkg::CELL_W'(cl);
		row.known.status = st;
		plan.push_back(row);
	endfunction

	// Drive one command and hold it until the core takes the transfer. Start
	// is left high, so back-to-back items never drop it within a step.
	task automatic issue_item(logic [1:0] op, logic signed [mdhc_pkg::VAL_W-1:0] v0,
			logic signed [mdhc_pkg::VAL_W-1:0] v1, logic signed [mdhc_pkg::VAL_W-1:0] v2,
			logic [mdhc_pkg::CELL_W-1:0] ridx, bit typed, histo_result_t known);
		int gap;
		histo_result_t want;
		// Mostly random gaps, with calm stretches of back-to-back items.
		if (calm_left > 0) begin
			gap = 0;
			calm_left--;
		end else if ($urandom_range(0, 40) == 0) begin
			calm_left = $urandom_range(10, 40);
			gap = 0;
		end else begin
			gap = $urandom_range(0, 10);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		value_0 <= v0;
		value_1 <= v1;
		value_2 <= v2;
		read_index <= ridx;
		do @(posedge clk); while (busy);
		want = tally_item(op, v0, v1, v2, ridx);
		if (typed)
			want = known;
		pending.push_back(want);
		if (op == mdhc_pkg::OP_COUNT) begin
			if (want.status)
				obs_flagged++;
			else
				obs_binned++;
		end
		if (op == mdhc_pkg::OP_READ || op == mdhc_pkg::OP_CLEAR)
			reads_done++;
		if (op == mdhc_pkg::OP_CLEAR)
			clears_done++;
	endtask

	// Drop start and hold until every pending result is back.
	task automatic settle();
		start <= 1'b0;
		while (pending.size() != 0 || busy)
			@(posedge clk);
	endtask

	// APB write: setup cycle, then access until pready, then idle.
	task automatic write_reg(mdhc_pkg::reg_e r, logic [mdhc_pkg::DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (r) inside
			mdhc_pkg::REG_DIMS: axes = data[1:0];
			mdhc_pkg::REG_LOW0, mdhc_pkg::REG_LOW1, mdhc_pkg::REG_LOW2:
				lower_bound[int'(r) - int'(mdhc_pkg::REG_LOW0)] = data[mdhc_pkg::VAL_W-1:0];
			default: span[int'(r) - int'(mdhc_pkg::REG_SIZE0)] = data[mdhc_pkg::SIZE_W-1:0];
		endcase
		@(posedge clk);
	endtask

	// Random item: mostly well-formed observations that land in the table,
	// plus boundary values, raw noise, reads, clears and the unused opcode.
	task automatic random_item();
		int roll;
		int used;
		int k;
		longint pick [3];
		longint reach;
		logic [1:0] op;
		logic [mdhc_pkg::CELL_W-1:0] ridx;
		histo_result_t none;
		none = '0;
		used = (axes == 2'd0) ? 1 : int'(axes);
		reach = 1;
		for (int d = 0; d < 3; d++) begin
			if (d < used && span[d] != 0) begin
				pick[d] = longint'(lower_bound[d]) + $urandom_range(0, span[d] - 1);
				if (pick[d] > 32767)
					pick[d] = lower_bound[d];
			end else begin
				pick[d] = longint'($urandom_range(0, 65535)) - 32768;
			end
			if (d < used)
				reach *= longint'(span[d]);
		end
		if (reach == 0 || reach > mdhc_pkg::CELLS)
			reach = mdhc_pkg::CELLS;
		roll = $urandom_range(0, 99);
		if (roll < 60) begin
			op = mdhc_pkg::OP_COUNT;
		end else if (roll < 66) begin
			// Step one coordinate just off either end of its range.
			op = mdhc_pkg::OP_COUNT;
			k = $urandom_range(0, used - 1);
			pick[k] = $urandom_range(0, 1) ? longint'(lower_bound[k]) - 1
				: longint'(lower_bound[k]) + longint'(span[k]);
			if (pick[k] < -32768 || pick[k] > 32767)
				pick[k] = lower_bound[k];
		end else if (roll < 72) begin
			op = mdhc_pkg::OP_COUNT;
			for (int d = 0; d < 3; d++)
				pick[d] = $urandom_range(0, 65535);
		end else if (roll < 86) begin
			op = mdhc_pkg::OP_READ;
		end else if (roll < 96) begin
			op = mdhc_pkg::OP_CLEAR;
		end else begin
			op = OP_UNUSED;
		end
		ridx = mdhc_pkg::CELL_W'(($urandom_range(0, 3) != 0) ? $urandom_range(0, reach - 1)
			: $urandom_range(0, mdhc_pkg::CELLS - 1));
		issue_item(op, pick[0][mdhc_pkg::VAL_W-1:0], pick[1][mdhc_pkg::VAL_W-1:0],
			pick[2][mdhc_pkg::VAL_W-1:0], ridx, 1'b0, none);
	endtask

	// Results come for one cycle and cannot be stalled: check each against
	// the oldest pending entry.
	always @(posedge clk) begin : watch_results
		histo_result_t want;
		if (arst_n && done) begin
			if (pending.size() == 0) begin
				report_mismatch("result with nothing pending, count", count, 0);
			end else begin
				want = pending.pop_front();
				if (count !== want.count)
					report_mismatch("count", count, want.count);
				if (cell_index !== want.cell_id)
					report_mismatch("cell_index", cell_index, want.cell_id);
				if (status !== want.status)
					report_mismatch("status", status, want.status);
			end
		end
	end

	initial begin : run
		int hold_at;
		int wait_n;
		int sz;
		int lo;
		histo_result_t stale;
		for (int i = 0; i < mdhc_pkg::CELLS; i++)
			tally[i] = '0;
		axes = 2'd1;
		for (int k = 0; k < 3; k++) begin
			lower_bound[k] = '0;
			span[k] = 13'd1;
		end

		// Reset values: one dimension, lower bound 0, size 1.
		add_item(1, mdhc_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0);
		add_item(1, mdhc_pkg::OP_READ, -1, -1, -1, 4095, 0, 4095, 0);
		add_item(1, mdhc_pkg::OP_COUNT, 0, 32767, -32768, 0, 1, 0, 0);
		add_item(1, mdhc_pkg::OP_COUNT, 1, 0, 0, 0, 0, 0, 1);
		add_item(1, mdhc_pkg::OP_COUNT, -1, 0, 0, 0, 0, 0, 1);
		add_item(1, OP_UNUSED, 0, 0, 0, 0, 0, 0, 1);
		add_item(1, mdhc_pkg::OP_CLEAR, 0, 0, 0, 0, 1, 0, 0);
		add_item(1, mdhc_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0);
		// Dimension count zero acts as one; widest first axis at the bottom.
		add_cfg(mdhc_pkg::REG_DIMS, 0);
		add_cfg(mdhc_pkg::REG_LOW0, -32768);
		add_cfg(mdhc_pkg::REG_SIZE0, 4096);
		add_item(1, mdhc_pkg::OP_COUNT, -32768, -1, -1, 0, 1, 0, 0);
		add_item(1, mdhc_pkg::OP_COUNT, -28673, 0, 0, 0, 1, 4095, 0);
		add_item(1, mdhc_pkg::OP_COUNT, 32767, 0, 0, 0, 0, 0, 1);
		// Three axes whose product overruns the table.
		add_cfg(mdhc_pkg::REG_DIMS, 3);
		add_cfg(mdhc_pkg::REG_LOW0, 32767);
		add_cfg(mdhc_pkg::REG_SIZE0, 1);
		add_cfg(mdhc_pkg::REG_LOW1, -5);
		add_cfg(mdhc_pkg::REG_SIZE1, 4096);
		add_cfg(mdhc_pkg::REG_LOW2, 0);
		add_cfg(mdhc_pkg::REG_SIZE2, 2);
		add_item(1, mdhc_pkg::OP_COUNT, 32767, -5, 1, 0, 0, 0, 1);
		add_item(0, mdhc_pkg::OP_COUNT, 32767, 4090, 0, 0, 0, 0, 0);
		add_item(1, mdhc_pkg::OP_COUNT, 32767, -6, 0, 0, 0, 0, 1);
		add_item(1, mdhc_pkg::OP_COUNT, 32766, 0, 0, 0, 0, 0, 1);
		// An axis of size zero rejects every coordinate.
		add_cfg(mdhc_pkg::REG_SIZE2, 0);
		add_item(1, mdhc_pkg::OP_COUNT, 32767, 0, 0, 0, 0, 0, 1);
		// Full-span offset on the second axis must not wrap into range.
		add_cfg(mdhc_pkg::REG_DIMS, 2);
		add_cfg(mdhc_pkg::REG_LOW1, -32768);
		add_item(1, mdhc_pkg::OP_COUNT, 32767, 32767, 0, 0, 0, 0, 1);
		add_item(0, mdhc_pkg::OP_COUNT, 32767, -32761, 9, 0, 0, 0, 0);
		add_item(0, mdhc_pkg::OP_COUNT, 32767, -32761, -9, 0, 0, 0, 0);
		add_item(0, mdhc_pkg::OP_CLEAR, 0, 0, 0, 7, 0, 0, 0);
		add_item(0, mdhc_pkg::OP_READ, 0, 0, 0, 7, 0, 0, 0);
		add_item(0, mdhc_pkg::OP_READ, 0, 0, 0, 4095, 0, 0, 0);
		add_item(1, OP_UNUSED, -1, -1, -1, 4095, 0, 0, 1);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Walk the directed table; register writes only once the core is idle.
		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				if (i == 0 || !plan[i - 1].is_cfg)
					settings_used++;
				settle();
				write_reg(plan[i].rsel, plan[i].wdata);
			end else begin
				issue_item(plan[i].op, plan[i].v0, plan[i].v1, plan[i].v2, plan[i].ridx,
					plan[i].typed, plan[i].known);
			end
		end

		// Random settings: every dimension count, with sizes and bounds often
		// at their extremes; small sizes keep cells hit over and over.
		for (int phase = 0; phase < RANDOM_SETTINGS; phase++) begin
			settle();
			for (int k = 0; k < 3; k++) begin
				case ($urandom_range(0, 9))
					0: sz = 0;
					1: sz = 4096;
					2: sz = 1;
					default: sz = $urandom_range(2, 24);
				endcase
				case ($urandom_range(0, 5))
					0: lo = -32768;
					1: lo = 32767;
					2: lo = (sz > 0) ? 32767 - sz + 1 : 32767;
					default: lo = int'($urandom_range(0, 65535)) - 32768;
				endcase
				write_reg(mdhc_pkg::reg_e'(int'(mdhc_pkg::REG_SIZE0) + k), sz);
				write_reg(mdhc_pkg::reg_e'(int'(mdhc_pkg::REG_LOW0) + k), lo);
			end
			write_reg(mdhc_pkg::REG_DIMS, phase % 4);
			settings_used++;
			// Hold off once per setting until the core has drained.
			hold_at = $urandom_range(20, ITEMS_PER_SETTING - 20);
			for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
				if (n == hold_at)
					settle();
				random_item();
			end
		end

		// Let the last results come back, then a few spare cycles.
		start <= 1'b0;
		for (wait_n = 0; wait_n < 2000 && pending.size() != 0; wait_n++)
			@(posedge clk);
		repeat (10) @(posedge clk);
		while (pending.size() != 0) begin
			stale = pending.pop_front();
			report_mismatch("missing result, count", 0, stale.count);
		end

		$display("Covered %0d binned and %0d rejected observations, %0d reads (%0d clearing)",
			obs_binned, obs_flagged, reads_done, clears_done);
		$display("across %0d register settings; %0d mismatches", settings_used, mismatch_count);
		if (mismatch_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

[sim.f]
+incdir+rtl
rtl/mdhc_pkg.sv
rtl/mdhc_ram.sv
rtl/mdhc_cfg.sv
rtl/mdhc_index.sv
rtl/multidim_histogram_counter_core.sv
bench/multidim_histogram_counter_core_test.sv
